@@ hdl/reduction_combine_alu_core_macros.svh @@
// Assertion macros used by the reduction combiner core.
`ifndef REDUCTION_COMBINE_ALU_CORE_MACROS_SVH
`define REDUCTION_COMBINE_ALU_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rca: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rca: next-cycle check failed");

`endif

@@ hdl/rca_pkg.sv @@
// Types, codes and helpers for the reduction combiner.
package rca_pkg;

    localparam int VALUE_W  = 64;
    localparam int HALF_W   = 32;
    localparam int INDEX_W  = 32;
    localparam int OP_W     = 4;
    localparam int ETYPE_W  = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;

    // Operation codes; codes above OP_MAXLOC are unsupported
    typedef enum logic [OP_W-1:0] {
        OP_SUM    = 4'd0,
        OP_PROD   = 4'd1,
        OP_MAX    = 4'd2,
        OP_MIN    = 4'd3,
        OP_LAND   = 4'd4,
        OP_LOR    = 4'd5,
        OP_BAND   = 4'd6,
        OP_BOR    = 4'd7,
        OP_MINLOC = 4'd8,
        OP_MAXLOC = 4'd9
    } t_op;

    // Element type codes; the fourth code is unsupported
    typedef enum logic [ETYPE_W-1:0] {
        ET_S64  = 2'd0,
        ET_S32  = 2'd1,
        ET_PAIR = 2'd2
    } t_etype;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TYPE = 4'd1;

    // Captured input item
    typedef struct packed {
        logic [VALUE_W-1:0] acc_value;
        logic [INDEX_W-1:0] acc_index;
        logic [VALUE_W-1:0] in_value;
        logic [INDEX_W-1:0] in_index;
        logic               last;
    } t_item;

    // Between first and second compute stage
    typedef struct packed {
        logic [VALUE_W-1:0] alt_value;  // final value for every op but product
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] p0;         // lo x lo
        logic [HALF_W-1:0]  p1;         // lo x hi, low half
        logic [HALF_W-1:0]  p2;         // hi x lo, low half
        logic               is_prod;
        logic               narrow;
        logic               err;
        logic               last;
    } t_mid;

    // Result item
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               err;
        logic               last;
    } t_res;

    function automatic logic [VALUE_W-1:0] sext32(input logic [HALF_W-1:0] v);
        return {{(VALUE_W-HALF_W){v[HALF_W-1]}}, v};
    endfunction

endpackage

@@ hdl/rca_in_if.sv @@
// Input item channel of the reduction combiner.
interface rca_in_if;
    import rca_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] acc_value;
    logic signed [INDEX_W-1:0] acc_index;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [INDEX_W-1:0] in_index;
    logic                      last_in;

    modport source (output valid, acc_value, acc_index, in_value, in_index, last_in,
                    input ready);
    modport sink   (input valid, acc_value, acc_index, in_value, in_index, last_in,
                    output ready);
endinterface

@@ hdl/rca_out_if.sv @@
// Result item channel of the reduction combiner.
interface rca_out_if;
    import rca_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic signed [INDEX_W-1:0] result_index;
    logic                      op_error;
    logic                      last_out;

    modport source (output valid, result_value, result_index, op_error, last_out,
                    input ready);
    modport sink   (input valid, result_value, result_index, op_error, last_out,
                    output ready);
endinterface

@@ hdl/rca_pre.sv @@
// First compute stage: operand decode, sum/compare/logic ops, pairs, partial products.
module rca_pre (
    input  rca_pkg::t_item                    i_item,
    input  logic [rca_pkg::OP_W-1:0]          i_operation,
    input  logic [rca_pkg::ETYPE_W-1:0]       i_element_type,
    output rca_pkg::t_mid                     o_mid
);
    import rca_pkg::*;

    logic               narrow;
    logic               int_ok;
    logic               pair_ok;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] sum;
    logic               lt_ab;
    logic               lt_ba;
    logic [VALUE_W-1:0] int_res;
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] y;
    logic               take_b;

    // Support check
    assign narrow  = (i_element_type == ET_S32);
    assign int_ok  = ((i_element_type == ET_S64) || narrow) && (i_operation <= OP_BOR);
    assign pair_ok = (i_element_type == ET_PAIR) &&
                     ((i_operation == OP_MINLOC) || (i_operation == OP_MAXLOC));

    // Operands, sign-extended from the low half in 32-bit mode
    assign a = narrow ? sext32(i_item.acc_value[HALF_W-1:0]) : i_item.acc_value;
    assign b = narrow ? sext32(i_item.in_value[HALF_W-1:0])  : i_item.in_value;

    assign sum   = a + b;
    assign lt_ab = $signed(a) < $signed(b);
    assign lt_ba = $signed(b) < $signed(a);

    // Integer ops other than product
    always_comb begin
        unique case (i_operation)
            OP_SUM:  int_res = sum;
            OP_MAX:  int_res = lt_ab ? b : a;
            OP_MIN:  int_res = lt_ba ? b : a;
            OP_LAND: int_res = {{(VALUE_W-1){1'b0}}, (a != '0) && (b != '0)};
            OP_LOR:  int_res = {{(VALUE_W-1){1'b0}}, (a != '0) || (b != '0)};
            OP_BAND: int_res = a & b;
            OP_BOR:  int_res = a | b;
            default: int_res = a;   // product is finished later; other codes unused
        endcase
    end

    // Minloc / maxloc; equal values go to the lower index
    assign x = sext32(i_item.acc_value[HALF_W-1:0]);
    assign y = sext32(i_item.in_value[HALF_W-1:0]);
    always_comb begin
        priority if (x == y) begin
            take_b = !($signed(i_item.acc_index) < $signed(i_item.in_index));
        end else if (i_operation == OP_MINLOC) begin
            take_b = $signed(y) < $signed(x);
        end else begin
            take_b = $signed(x) < $signed(y);
        end
    end

    // Result selection and partial products
    always_comb begin
        o_mid = '0;
        o_mid.p0 = VALUE_W'(a[HALF_W-1:0]) * VALUE_W'(b[HALF_W-1:0]);
        o_mid.p1 = a[HALF_W-1:0] * b[VALUE_W-1:HALF_W];
        o_mid.p2 = a[VALUE_W-1:HALF_W] * b[HALF_W-1:0];
        o_mid.narrow  = narrow;
        o_mid.last    = i_item.last;
        o_mid.is_prod = int_ok && (i_operation == OP_PROD);
        o_mid.index   = i_item.acc_index;
        priority if (int_ok) begin
            o_mid.alt_value = narrow ? sext32(int_res[HALF_W-1:0]) : int_res;
        end else if (pair_ok) begin
            o_mid.alt_value = take_b ? y : x;
            o_mid.index     = take_b ? i_item.in_index : i_item.acc_index;
        end else begin
            o_mid.alt_value = i_item.acc_value;
            o_mid.err       = 1'b1;
        end
    end
endmodule

@@ hdl/rca_post.sv @@
// Second compute stage: product assembly and final value select.
module rca_post (
    input  rca_pkg::t_mid i_mid,
    output rca_pkg::t_res o_res
);
    import rca_pkg::*;

    logic [VALUE_W-1:0] prod;

    // Low 64 bits of the product from the three partial products
    assign prod = i_mid.p0 + {i_mid.p1 + i_mid.p2, {HALF_W{1'b0}}};

    always_comb begin
        o_res.index = i_mid.index;
        o_res.err   = i_mid.err;
        o_res.last  = i_mid.last;
        priority if (i_mid.is_prod && i_mid.narrow) begin
            o_res.value = sext32(i_mid.p0[HALF_W-1:0]);
        end else if (i_mid.is_prod) begin
            o_res.value = prod;
        end else begin
            o_res.value = i_mid.alt_value;
        end
    end
endmodule

@@ hdl/reduction_combine_alu_core.sv @@
// The result passes through the input, partial-product and result registers.
// Throughput: one item per cycle while o_out.ready holds; the 64-bit product is
// split into 32x32 partial products in the first stage and summed in the second.
// Each stage advances when the one after it is empty or moving, so bubbles close up.
// Reset (synchronous, active low) empties all stages and sets operation to sum and
// element type to signed 64-bit.
module reduction_combine_alu_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rca_in_if.sink                           i_in,
    rca_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [rca_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rca_pkg::*;

    `include "reduction_combine_alu_core_macros.svh"

    logic [OP_W-1:0]    r_operation;
    logic [ETYPE_W-1:0] r_element_type;

    logic  r_v1, r_v2, r_v3;
    t_item r_item;
    t_mid  r_mid;
    t_mid  n_mid;
    t_res  r_res;
    t_res  n_res;
    logic  rdy_s1, rdy_s2, rdy_s3;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation    <= OP_SUM;
            r_element_type <= ET_S64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_OPERATION) begin
                r_operation <= i_cfg_data[OP_W-1:0];
            end else if (i_cfg_index == CFG_ELEMENT_TYPE) begin
                r_element_type <= i_cfg_data[ETYPE_W-1:0];
            end
        end
    end

    // Stage readiness
    assign rdy_s3 = !r_v3 || o_out.ready;
    assign rdy_s2 = !r_v2 || rdy_s3;
    assign rdy_s1 = !r_v1 || rdy_s2;
    assign i_in.ready = rdy_s1;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy_s1) r_v1 <= i_in.valid;
            if (rdy_s2) r_v2 <= r_v1;
            if (rdy_s3) r_v3 <= r_v2;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_item.acc_value <= i_in.acc_value;
            r_item.acc_index <= i_in.acc_index;
            r_item.in_value  <= i_in.in_value;
            r_item.in_index  <= i_in.in_index;
            r_item.last      <= i_in.last_in;
        end
        if (rdy_s2) r_mid <= n_mid;
        if (rdy_s3) r_res <= n_res;
    end

    rca_pre u_pre (
        .i_item         (r_item),
        .i_operation    (r_operation),
        .i_element_type (r_element_type),
        .o_mid          (n_mid)
    );

    rca_post u_post (
        .i_mid (r_mid),
        .o_res (n_res)
    );

    // Result channel
    assign o_out.valid        = r_v3;
    assign o_out.result_value = r_res.value;
    assign o_out.result_index = r_res.index;
    assign o_out.op_error     = r_res.err;
    assign o_out.last_out     = r_res.last;

    // Input is refused only with every stage full
    `RCA_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, !i_in.ready, r_v1 && r_v2 && r_v3)
    // A product is never flagged as unsupported
    `RCA_ASSERT_NOW(a_prod_no_err, i_clk, i_rst_n, r_v2 && r_mid.is_prod, !r_mid.err)
    // Result taken with nothing behind it leaves the output empty
    `RCA_ASSERT_NEXT(a_drain, i_clk, i_rst_n, o_out.valid && o_out.ready && !r_v2, !o_out.valid)
endmodule
